FILE: rtl/mbrp_pkg.sv
// ----------------------------------------------------------------------------
// mbrp_pkg
// Shared constants and types of the Modbus response parser.
// ----------------------------------------------------------------------------
package mbrp_pkg;

  localparam int MaxFrame = 64;
  localparam int AddrW    = $clog2(MaxFrame);
  localparam int CntW     = $clog2(MaxFrame + 1);

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_LONG  = 3'd1;
  localparam logic [2:0] ST_BAD   = 3'd2;
  localparam logic [2:0] ST_EXC   = 3'd3;
  localparam logic [2:0] ST_UNSUP = 3'd4;
  localparam logic [2:0] ST_CRC   = 3'd5;
  localparam logic [2:0] ST_EMPTY = 3'd6;

  localparam logic [1:0] KIND_BITS = 2'd0;
  localparam logic [1:0] KIND_REG  = 2'd1;
  localparam logic [1:0] KIND_SW   = 2'd2;
  localparam logic [1:0] KIND_AN   = 2'd3;

  localparam logic [0:0] REG_MODE = 1'b0;
  localparam logic [0:0] REG_MAX  = 1'b1;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // frame descriptor handed from the front end to the decoder
  typedef struct packed {
    logic [CntW-1:0] len;
    logic            ovf;
    logic [15:0]     crc;
  } frame_desc_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] x;
    x = c ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
    end
    return x;
  endfunction

endpackage

FILE: rtl/mbrp_ram.sv
// ----------------------------------------------------------------------------
// mbrp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbrp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/mbrp_front.sv
// ----------------------------------------------------------------------------
// mbrp_front
// Accept bytes, write them to the store, run the CRC and count the frame.
// ----------------------------------------------------------------------------
module mbrp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_rx_byte,
  input  logic                       in_frame_end,
  output logic                       we,
  output logic [mbrp_pkg::AddrW-1:0] waddr,
  output logic [7:0]                 wdata,
  output logic                       q_push,
  output mbrp_pkg::frame_desc_t      q_desc,
  input  logic                       q_full
);
  import mbrp_pkg::*;

  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic [15:0]     c0_r, c0_nxt, c1_r, c1_nxt, c2_r, c2_nxt;
  logic            acc, room;

  // c0 is the CRC over all stored bytes so far, c1 lags by one byte, c2 by two
  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign room     = cnt_r < CntW'(MaxFrame);
  assign we       = acc && room;
  assign waddr    = cnt_r[AddrW-1:0];
  assign wdata    = in_rx_byte;
  assign q_push   = acc && in_frame_end;

  always_comb begin
    q_desc.len = cnt_r + CntW'(room);
    q_desc.ovf = ovf_r || !room;
    q_desc.crc = room ? c1_r : c2_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    c0_nxt  = c0_r;
    c1_nxt  = c1_r;
    c2_nxt  = c2_r;
    if (acc) begin
      if (in_frame_end) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
        c0_nxt  = CrcInit;
        c1_nxt  = CrcInit;
        c2_nxt  = CrcInit;
      end else if (room) begin
        cnt_nxt = cnt_r + 1'b1;
        c0_nxt  = crc_byte(c0_r, in_rx_byte);
        c1_nxt  = c0_r;
        c2_nxt  = c1_r;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
      c0_r  <= CrcInit;
      c1_r  <= CrcInit;
      c2_r  <= CrcInit;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      c0_r  <= c0_nxt;
      c1_r  <= c1_nxt;
      c2_r  <= c2_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CntW'(MaxFrame))
    else $error("byte count beyond store");
  assert property (@(posedge clk) disable iff (!rst_n) ovf_r |-> cnt_r == CntW'(MaxFrame))
    else $error("overflow with free space");
  assert property (@(posedge clk) disable iff (!rst_n) q_push |=> cnt_r == '0 && !ovf_r)
    else $error("counters not cleared at frame end");
endmodule

FILE: rtl/mbrp_back.sv
// ----------------------------------------------------------------------------
// mbrp_back
// Pop a frame descriptor, read header bytes, check and emit results.
// ----------------------------------------------------------------------------
module mbrp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       mode,
  input  logic [6:0]                 max_bytes,
  input  logic                       q_valid,
  input  mbrp_pkg::frame_desc_t      q_desc,
  output logic                       q_pop,
  output logic                       busy,
  output logic [mbrp_pkg::AddrW-1:0] raddr,
  input  logic [7:0]                 rdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic [1:0]                 out_point_kind,
  output logic [15:0]                out_point_address,
  output logic [15:0]                out_point_value,
  output logic                       out_last_result
);
  import mbrp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HDR  = 6'b000010,
    S_DEC  = 6'b000100,
    S_PT   = 6'b001000,
    S_PUT  = 6'b010000,
    S_WAIT = 6'b100000
  } st_t;

  st_t             st_r, st_nxt;
  frame_desc_t     d_r, d_nxt;
  logic [3:0]      hi_r, hi_nxt;      // header read index
  logic [3:0]      hv_r, hv_nxt;      // index of byte arriving this cycle
  logic            hd_r, hd_nxt;      // read in flight
  logic [7:0]      h_r [9];
  logic [7:0]      fc_r, bc_r;
  logic [CntW-1:0] ds_r, dl_r;
  logic [CntW-1:0] pi_r, pi_nxt, pn_r;
  logic            wide_r;
  logic            ph_r, ph_nxt;
  logic [7:0]      hib_r, hib_nxt;
  logic [2:0]      o_st_r, o_st_nxt;
  logic [1:0]      o_k_r, o_k_nxt;
  logic [15:0]     o_a_r, o_a_nxt, o_v_r, o_v_nxt;
  logic            o_l_r, o_l_nxt;
  logic            o_vld_r, o_vld_nxt;
  logic [CntW-1:0] hdr_n, tail;
  logic [15:0]     mlen;

  // header bytes: TCP 0..8, RTU 0..2 then two CRC bytes at len-2, len-1
  assign hdr_n = mode ? CntW'(9) : CntW'(5);
  assign mlen  = {h_r[4], h_r[5]};
  assign tail  = d_r.len - CntW'(2);
  assign busy  = st_r != S_IDLE;

  always_comb begin
    raddr = hi_r[AddrW-1:0];
    if (!mode) begin
      if (hi_r == 4'd3) raddr = tail[AddrW-1:0];
      else if (hi_r == 4'd4) raddr = AddrW'(tail + CntW'(1));
    end
    if (st_r == S_PT) begin
      raddr = AddrW'(ds_r + CntW'(1) + pi_r * (wide_r ? CntW'(2) : CntW'(1))
                     + CntW'(ph_r));
    end
  end

  always_comb begin
    st_nxt    = st_r;
    d_nxt     = d_r;
    hi_nxt    = hi_r;
    hv_nxt    = hi_r;
    hd_nxt    = 1'b0;
    pi_nxt    = pi_r;
    ph_nxt    = ph_r;
    hib_nxt   = hib_r;
    o_st_nxt  = o_st_r;
    o_k_nxt   = o_k_r;
    o_a_nxt   = o_a_r;
    o_v_nxt   = o_v_r;
    o_l_nxt   = o_l_r;
    o_vld_nxt = o_vld_r && !out_ready;
    q_pop     = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          d_nxt  = q_desc;
          hi_nxt = '0;
          st_nxt = S_HDR;
        end
      end
      S_HDR: begin
        if (CntW'(hi_r) < hdr_n) begin
          hd_nxt = 1'b1;
          hi_nxt = hi_r + 1'b1;
        end else if (!hd_r) begin
          st_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!o_vld_r || out_ready) begin
          st_nxt   = S_PUT;
          o_k_nxt  = KIND_BITS;
          o_a_nxt  = '0;
          o_v_nxt  = '0;
          o_l_nxt  = 1'b1;
          o_st_nxt = ST_OK;
          if (d_r.ovf || d_r.len > CntW'(max_bytes)) begin
            o_st_nxt = ST_LONG;
          end else if (mode && (d_r.len < CntW'(8) ||
                                17'(d_r.len) < 17'(mlen) + 17'd6 || mlen < 16'd2)) begin
            o_st_nxt = ST_BAD;
          end else if (!mode && d_r.len < CntW'(4)) begin
            o_st_nxt = ST_BAD;
          end else if (!mode && d_r.crc != {h_r[4], h_r[3]}) begin
            o_st_nxt = ST_CRC;
          end else if (fc_r[7]) begin
            o_st_nxt = ST_EXC;
            o_v_nxt  = (dl_r >= CntW'(1)) ? {8'h00, bc_r} : 16'h0000;
          end else if (fc_r >= 8'd1 && fc_r <= 8'd4) begin
            if (dl_r < CntW'(1) || 9'(dl_r) < 9'(bc_r) + 9'd1) begin
              o_st_nxt = ST_BAD;
            end else if (pn_r == '0) begin
              o_st_nxt = ST_EMPTY;
            end else begin
              pi_nxt = '0;
              ph_nxt = 1'b0;
              hd_nxt = 1'b0;
              st_nxt = S_PT;
            end
          end else if (fc_r == 8'd5 || fc_r == 8'd6) begin
            if (dl_r < CntW'(4)) begin
              o_st_nxt = ST_BAD;
            end else begin
              o_k_nxt = (fc_r == 8'd5) ? KIND_SW : KIND_AN;
              o_a_nxt = mode ? {h_r[8], 8'h00} : {h_r[2], 8'h00};
              st_nxt  = S_PT;
              pi_nxt  = '0;
              ph_nxt  = 1'b0;
            end
          end else begin
            o_st_nxt = ST_UNSUP;
          end
        end
      end
      S_PT: begin
        // issue a read, then capture in S_WAIT
        if (!o_vld_r || out_ready) begin
          st_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        st_nxt = S_PT;
        if (fc_r == 8'd5 || fc_r == 8'd6) begin
          // reads at ds+1+0/1/2.. are address lo, value hi, value lo
          ph_nxt = ph_r;
          pi_nxt = pi_r + 1'b1;
          if (pi_r == CntW'(0)) begin
            o_a_nxt = {o_a_r[15:8], rdata};
          end else if (pi_r == CntW'(1)) begin
            hib_nxt = rdata;
          end else begin
            o_v_nxt   = {hib_r, rdata};
            o_l_nxt   = 1'b1;
            o_st_nxt  = ST_OK;
            o_vld_nxt = 1'b1;
            st_nxt    = S_IDLE;
          end
        end else if (wide_r && !ph_r) begin
          hib_nxt = rdata;
          ph_nxt  = 1'b1;
        end else begin
          o_st_nxt  = ST_OK;
          o_k_nxt   = wide_r ? KIND_REG : KIND_BITS;
          o_a_nxt   = wide_r ? 16'(pi_r) : 16'({pi_r, 3'b000});
          o_v_nxt   = wide_r ? {hib_r, rdata} : {8'h00, rdata};
          o_l_nxt   = (pi_r + 1'b1 == pn_r);
          o_vld_nxt = 1'b1;
          ph_nxt    = 1'b0;
          pi_nxt    = pi_r + 1'b1;
          st_nxt    = (pi_r + 1'b1 == pn_r) ? S_IDLE : S_PT;
        end
      end
      S_PUT: begin
        if (!o_vld_r || out_ready) begin
          o_vld_nxt = 1'b1;
          st_nxt    = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      o_vld_r <= 1'b0;
      hd_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      o_vld_r <= o_vld_nxt;
      hd_r    <= hd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    hi_r   <= hi_nxt;
    hv_r   <= hv_nxt;
    pi_r   <= pi_nxt;
    ph_r   <= ph_nxt;
    hib_r  <= hib_nxt;
    o_st_r <= o_st_nxt;
    o_k_r  <= o_k_nxt;
    o_a_r  <= o_a_nxt;
    o_v_r  <= o_v_nxt;
    o_l_r  <= o_l_nxt;
    if (hd_r) begin
      h_r[hv_r] <= rdata;
    end
  end

  // derived frame fields, registered from the header bytes without an enable
  always_ff @(posedge clk) begin
    if (mode) begin
      fc_r <= h_r[7];
      bc_r <= h_r[8];
      ds_r <= CntW'(8);
      dl_r <= CntW'(mlen - 16'd2);
    end else begin
      fc_r <= h_r[1];
      bc_r <= h_r[2];
      ds_r <= CntW'(2);
      dl_r <= d_r.len - CntW'(4);
    end
    wide_r <= mode ? (h_r[7] == 8'd3 || h_r[7] == 8'd4) :
                     (h_r[1] == 8'd3 || h_r[1] == 8'd4);
    if (mode) begin
      pn_r <= (h_r[7] == 8'd3 || h_r[7] == 8'd4) ? CntW'(h_r[8] >> 1) : CntW'(h_r[8]);
    end else begin
      pn_r <= (h_r[1] == 8'd3 || h_r[1] == 8'd4) ? CntW'(h_r[2] >> 1) : CntW'(h_r[2]);
    end
  end

  assign out_valid         = o_vld_r;
  assign out_status        = o_st_r;
  assign out_point_kind    = o_k_r;
  assign out_point_address = o_a_r;
  assign out_point_value   = o_v_r;
  assign out_last_result   = o_l_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last_result)
    else $error("status result not last");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == S_IDLE)
    else $error("pop while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK && out_status != ST_EXC |-> out_point_value == '0)
    else $error("status result carries a value");
endmodule

FILE: rtl/modbus_response_parser.sv
// ----------------------------------------------------------------------------
// modbus_response_parser
// Modbus RTU/TCP response parser: buffers a frame, checks it, emits points.
// ----------------------------------------------------------------------------
// One byte accepted per cycle while in_ready is high; from frame end, hold input until the
// last result is issued. After frame end: pop, header fetch, decode; then a single status
// result, or one result per bit group, per register or per echo.
// Synchronous active-low reset clears control, sets mode RTU, max 64 bytes.
module modbus_response_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [1:0]  out_point_kind,
  output logic [15:0] out_point_address,
  output logic [15:0] out_point_value,
  output logic        out_last_result,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mbrp_pkg::*;

  logic              mode_r;
  logic [6:0]        max_r;
  logic              we, q_push, q_pop, q_full, q_valid, ren_blk, b_busy;
  logic [AddrW-1:0]  waddr, raddr;
  logic [7:0]        wdata, rdata;
  frame_desc_t       f_desc, b_desc;
  frame_desc_t       q_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        qc_r;

  assign cfg_pready = 1'b1;
  always_comb begin
    unique case (cfg_paddr[2])
      REG_MODE: cfg_prdata = {31'd0, mode_r};
      REG_MAX:  cfg_prdata = {25'd0, max_r};
      default:  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      max_r  <= 7'd64;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == {REG_MODE, 2'b00}) mode_r <= cfg_pwdata[0];
      if (cfg_paddr == {REG_MAX, 2'b00})  max_r  <= cfg_pwdata[6:0];
    end
  end

  // two-entry descriptor queue
  assign q_full  = qc_r == 2'd2;
  assign q_valid = qc_r != 2'd0;
  assign b_desc  = q_r[rp_r];
  assign ren_blk = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      qc_r <= '0;
    end else begin
      if (q_push) wp_r <= !wp_r;
      if (q_pop)  rp_r <= !rp_r;
      qc_r <= qc_r + 2'(q_push) - 2'(q_pop);
    end
  end
  always_ff @(posedge clk) begin
    if (q_push) q_r[wp_r] <= f_desc;
  end

  mbrp_ram #(.Width(8), .Depth(MaxFrame)) u_ram (
    .clk(clk), .we(we && !ren_blk), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  mbrp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_rx_byte(in_rx_byte), .in_frame_end(in_frame_end),
    .we(we), .waddr(waddr), .wdata(wdata),
    .q_push(q_push), .q_desc(f_desc), .q_full(q_full || q_valid || b_busy)
  );

  mbrp_back u_back (
    .clk(clk), .rst_n(rst_n), .mode(mode_r), .max_bytes(max_r),
    .q_valid(q_valid), .q_desc(b_desc), .q_pop(q_pop), .busy(b_busy),
    .raddr(raddr), .rdata(rdata),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_point_kind(out_point_kind), .out_point_address(out_point_address),
    .out_point_value(out_point_value), .out_last_result(out_last_result)
  );

  assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
    else $error("queue overrun");
  assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && !q_valid))
    else $error("queue underrun");
  assert property (@(posedge clk) disable iff (!rst_n) qc_r <= 2'd2)
    else $error("queue count out of range");
endmodule
